// File: hdl/vfr_pkg.sv
// ---------------------------------------------------------------------------
// vfr_pkg: shared types and constants
// Field widths, register reset values, register indexes and class codes.
// ---------------------------------------------------------------------------
`default_nettype none

package vfr_pkg;

  localparam int H_W      = 13;
  localparam int V_W      = 11;
  localparam int X_W      = 12;
  localparam int REF_W    = 27;
  localparam int CLK_W    = 32;
  localparam int RATE_W   = 8;
  localparam int SHIFT    = 11;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [REF_W-1:0]  REF_CLOCK_RESET    = REF_W'(28322000);
  localparam logic [CLK_W-1:0]  HD_THRESHOLD_RESET = CLK_W'(74363406);
  localparam logic [RATE_W-1:0] RATE_BIAS          = RATE_W'(3);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_CLOCK    = 2'd0,
    REG_HD_THRESHOLD = 2'd1
  } reg_index_t;

  localparam logic CLASS_HD = 1'b0;
  localparam logic CLASS_SD = 1'b1;

endpackage

`default_nettype wire

// File: hdl/vfr_if.sv
// ---------------------------------------------------------------------------
// vfr_if: measurement and result channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ---------------------------------------------------------------------------
`default_nettype none

interface vfr_in_if;
  logic                       valid;
  logic                       ready;
  logic [vfr_pkg::H_W-1:0]    h_total;
  logic [vfr_pkg::V_W-1:0]    v_total;
  logic [vfr_pkg::X_W-1:0]    xclk_count;

  modport source (output valid, h_total, v_total, xclk_count, input ready);
  modport sink   (input valid, h_total, v_total, xclk_count, output ready);
endinterface

interface vfr_out_if;
  logic                       valid;
  logic                       ready;
  logic [vfr_pkg::RATE_W-1:0] field_rate_hz;
  logic                       clock_class;
  logic [vfr_pkg::CLK_W-1:0]  pixel_clock_hz;
  logic                       divide_error;

  modport source (output valid, field_rate_hz, clock_class, pixel_clock_hz, divide_error,
                  input ready);
  modport sink   (input valid, field_rate_hz, clock_class, pixel_clock_hz, divide_error,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/vfr_div_pipe.sv
// ---------------------------------------------------------------------------
// vfr_div_pipe: pipelined restoring divider
// One quotient bit per register stage, sideband carried alongside.
// ---------------------------------------------------------------------------
`default_nettype none

module vfr_div_pipe #(
  parameter int NW = 27,
  parameter int DW = 13,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          adv,
  input  wire logic          in_vld,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] sb_in,
  output logic               out_vld,
  output logic [NW-1:0]      quo,
  output logic [SW-1:0]      sb_out
);

  logic          vld_s [0:NW];
  logic [NW-1:0] num_s [0:NW];
  logic [DW-1:0] den_s [0:NW];
  logic [DW-1:0] rem_s [0:NW];
  logic [NW-1:0] quo_s [0:NW];
  logic [SW-1:0] sb_s  [0:NW];

  assign vld_s[0] = in_vld;
  assign num_s[0] = num;
  assign den_s[0] = den;
  assign rem_s[0] = '0;
  assign quo_s[0] = '0;
  assign sb_s[0]  = sb_in;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0]   partial;
    logic [DW:0]   diff;
    logic          ge;

    assign partial = {rem_s[i], num_s[i][NW-1]};
    assign ge      = partial >= {1'b0, den_s[i]};
    assign diff    = partial - {1'b0, den_s[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_s[i+1] <= 1'b0;
      end else if (adv) begin
        vld_s[i+1] <= vld_s[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        num_s[i+1] <= {num_s[i][NW-2:0], 1'b0};
        den_s[i+1] <= den_s[i];
        rem_s[i+1] <= ge ? diff[DW-1:0] : partial[DW-1:0];
        quo_s[i+1] <= {quo_s[i][NW-2:0], ge};
        sb_s[i+1]  <= sb_s[i];
      end
    end
  end

  assign out_vld = vld_s[NW];
  assign quo     = quo_s[NW];
  assign sb_out  = sb_s[NW];

endmodule

`default_nettype wire

// File: hdl/vfr_finish.sv
// ---------------------------------------------------------------------------
// vfr_finish: result stage
// Add the rate bias, zero values on error, classify, and register the result.
// ---------------------------------------------------------------------------
`default_nettype none

module vfr_finish (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       adv,
  input  wire logic                       in_vld,
  input  wire logic                       err,
  input  wire logic [vfr_pkg::CLK_W-1:0]  rate_quo,
  input  wire logic [vfr_pkg::CLK_W-1:0]  pclk,
  input  wire logic [vfr_pkg::CLK_W-1:0]  threshold,
  output logic                            valid,
  output logic [vfr_pkg::RATE_W-1:0]      field_rate_hz,
  output logic                            clock_class,
  output logic [vfr_pkg::CLK_W-1:0]       pixel_clock_hz,
  output logic                            divide_error
);
  import vfr_pkg::*;

  logic [RATE_W-1:0] rate_next;
  logic [CLK_W-1:0]  pclk_next;

  assign rate_next = err ? '0 : rate_quo[RATE_W-1:0] + RATE_BIAS;
  assign pclk_next = err ? '0 : pclk;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      field_rate_hz  <= rate_next;
      pixel_clock_hz <= pclk_next;
      clock_class    <= (pclk_next > threshold) ? CLASS_HD : CLASS_SD;
      divide_error   <= err;
    end
  end

endmodule

`default_nettype wire

// File: hdl/video_field_rate_and_clock_class.sv
// ---------------------------------------------------------------------------
// video_field_rate_and_clock_class: field rate and pixel clock class
// Computes field rate ((ref/h/v)<<11)/xclk + 3 and pixel clock (ref/xclk)<<11
// from one measurement set, and classes the pixel clock as HD or SD.
// ---------------------------------------------------------------------------
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------------
//  meas     | in  | h_total, v_total, xclk_count
//  result   | out | field_rate_hz, clock_class, pixel_clock_hz, divide_error
//  cfg      | in  | cfg_write, cfg_index, cfg_data (write only)
//
//  One measurement transfer per cycle while result is not stalled; the path is three
//  bit-per-stage dividers in series (27 + 27 + 32 stages) and the result stage.
//  rst is synchronous and clears the valid bits and loads register defaults.
//  A stall on result freezes the whole pipeline in place; meas.ready is low
//  only while the result register holds an untaken transfer.
//
`default_nettype none

module video_field_rate_and_clock_class (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [vfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [vfr_pkg::CFG_W-1:0]       cfg_data,
  vfr_in_if.sink                               meas,
  vfr_out_if.source                            result
);
  import vfr_pkg::*;

  // configuration registers
  logic [REF_W-1:0] ref_clock;
  logic [CLK_W-1:0] threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock <= REF_CLOCK_RESET;
      threshold <= HD_THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_REF_CLOCK:    ref_clock <= cfg_data[REF_W-1:0];
        REG_HD_THRESHOLD: threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // global advance: move everything when the result register is free
  logic adv;
  assign adv        = !result.valid || result.ready;
  assign meas.ready = adv;

  logic err_in;
  assign err_in = (meas.h_total == '0) || (meas.v_total == '0) || (meas.xclk_count == '0);

  // first divider group: ref/h and, in parallel, ref/xclk
  logic                 a1_vld, a2_vld;
  logic [REF_W-1:0]     a1_quo, a2_quo;
  logic [V_W+X_W-1:0]   a1_sb;
  logic                 a2_err;

  vfr_div_pipe #(.NW(REF_W), .DW(H_W), .SW(V_W + X_W)) u_div_h (
    .clk, .rst, .adv,
    .in_vld (meas.valid),
    .num    (ref_clock),
    .den    (meas.h_total),
    .sb_in  ({meas.v_total, meas.xclk_count}),
    .out_vld(a1_vld),
    .quo    (a1_quo),
    .sb_out (a1_sb)
  );

  vfr_div_pipe #(.NW(REF_W), .DW(X_W), .SW(1)) u_div_x (
    .clk, .rst, .adv,
    .in_vld (meas.valid),
    .num    (ref_clock),
    .den    (meas.xclk_count),
    .sb_in  (err_in),
    .out_vld(a2_vld),
    .quo    (a2_quo),
    .sb_out (a2_err)
  );

  // pixel clock wraps at 32 bits after the shift
  logic [CLK_W-1:0] pclk_a;
  assign pclk_a = {a2_quo[CLK_W-SHIFT-1:0], SHIFT'(0)};

  // second divider: (ref/h)/v
  logic                   b_vld;
  logic [REF_W-1:0]       b_quo;
  logic [X_W+CLK_W:0]     b_sb;

  vfr_div_pipe #(.NW(REF_W), .DW(V_W), .SW(X_W + CLK_W + 1)) u_div_v (
    .clk, .rst, .adv,
    .in_vld (a1_vld && a2_vld),
    .num    (a1_quo),
    .den    (a1_sb[V_W+X_W-1:X_W]),
    .sb_in  ({a1_sb[X_W-1:0], a2_err, pclk_a}),
    .out_vld(b_vld),
    .quo    (b_quo),
    .sb_out (b_sb)
  );

  // scale per-frame count by 2048, wrapping at 32 bits
  logic [CLK_W-1:0] scaled;
  assign scaled = {b_quo[CLK_W-SHIFT-1:0], SHIFT'(0)};

  // third divider: scaled / xclk
  logic               c_vld;
  logic [CLK_W-1:0]   c_quo;
  logic [CLK_W:0]     c_sb;

  vfr_div_pipe #(.NW(CLK_W), .DW(X_W), .SW(CLK_W + 1)) u_div_r (
    .clk, .rst, .adv,
    .in_vld (b_vld),
    .num    (scaled),
    .den    (b_sb[X_W+CLK_W:CLK_W+1]),
    .sb_in  (b_sb[CLK_W:0]),
    .out_vld(c_vld),
    .quo    (c_quo),
    .sb_out (c_sb)
  );

  // bias, error masking, classification and the output register
  vfr_finish u_finish (
    .clk, .rst, .adv,
    .in_vld        (c_vld),
    .err           (c_sb[CLK_W]),
    .rate_quo      (c_quo),
    .pclk          (c_sb[CLK_W-1:0]),
    .threshold     (threshold),
    .valid         (result.valid),
    .field_rate_hz (result.field_rate_hz),
    .clock_class   (result.clock_class),
    .pixel_clock_hz(result.pixel_clock_hz),
    .divide_error  (result.divide_error)
  );

endmodule

`default_nettype wire
